/* rtl/double_ended_queue_macros.svh */
// Assertion macros used by the double-ended queue RTL.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DEQ_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define DEQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/deq_pkg.sv */
// Types and codes shared by the double-ended queue.
`default_nettype none

package deq_pkg;

   localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [2:0] CMD_POP_BACK   = 3'd3;
   localparam logic [2:0] CMD_QUERY      = 3'd4;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]         command;
      logic signed [31:0] push_value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] popped_value;
      logic [10:0]        entry_count;
      logic               is_empty;
      logic signed [31:0] front_value;
      logic signed [31:0] back_value;
   } rsp_type;

endpackage

`default_nettype wire

/* rtl/double_ended_queue.sv */
// Double-ended queue of signed words held in a ring buffer RAM.
//
// Usage:
//   req_valid/req_ready/req_data carry one command word: push front, push
//   back, pop front, pop back or query (unused codes act as query).
//   rsp_valid/rsp_ready/rsp_data return exactly one result word per command:
//   status, popped value, entry count, empty flag, and the front and back
//   entries as they stand after the command.
// Timing:
//   Push, query and pops that leave fewer than two entries: the result is
//   registered at accept; one command per cycle while the output drains.
//   Pops that leave two or more entries pass through S_READ, because the new
//   front (or back) entry must come out of the RAM, whose read is registered.
//   The front and back entries are cached in registers; the RAM is touched
//   by at most one write (push) or one read (pop) per command.
// Reset:
//   Synchronous, active high. The queue comes up empty with the head at
//   slot zero. RAM contents are not cleared; only written slots are read.
// Stalls:
//   A command is still accepted while a result waits in the output register;
//   its result parks in a holding register and no further command is taken
//   until the output register drains.
`default_nettype none

module double_ended_queue #(
   parameter int DEPTH      = 1024,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire deq_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output deq_pkg::rsp_type      rsp_data
);

   import deq_pkg::*;

`include "double_ended_queue_macros.svh"

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_HOLD
   } state_type;

   // Fold a ring sum that stays below twice the depth.
   function automatic logic [AW-1:0] wrap_idx(input logic [SW-1:0] sum);
      logic [SW-1:0] t;
      t = (sum >= SW'(DEPTH)) ? sum - SW'(DEPTH) : sum;
      return t[AW-1:0];
   endfunction

   state_type            state_ff, state_in;
   logic [AW-1:0]        head_ff, head_in;
   logic [CW-1:0]        occ_ff, occ_in;
   logic [DATA_WIDTH-1:0] front_ff, front_in;
   logic [DATA_WIDTH-1:0] back_ff, back_in;
   logic [DATA_WIDTH-1:0] popped_ff, popped_in;
   logic                 side_ff, side_in;   // 1: read refills front
   rsp_type              res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                 ram_we;
   logic [AW-1:0]        ram_waddr;
   logic                 ram_re;
   logic [AW-1:0]        ram_raddr;
   logic [DATA_WIDTH-1:0] ram_rdata;

   logic [2:0]           cmd;
   logic [DATA_WIDTH-1:0] word;
   logic [AW-1:0]        head_inc;
   logic [AW-1:0]        head_dec;
   logic                 q_empty;
   logic                 q_full;
   logic                 out_free;
   logic                 done;
   logic [1:0]           status;
   logic [DATA_WIDTH-1:0] popped;
   rsp_type              result;

   assign cmd      = req_data.command;
   assign word     = DATA_WIDTH'(req_data.push_value);
   assign head_inc = wrap_idx(SW'(head_ff) + SW'(1));
   assign head_dec = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);
   assign q_empty  = (occ_ff == '0);
   assign q_full   = (occ_ff == CW'(DEPTH));
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      occ_in       = occ_ff;
      front_in     = front_ff;
      back_in      = back_ff;
      popped_in    = popped_ff;
      side_in      = side_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_waddr    = head_dec;
      ram_re       = 1'b0;
      ram_raddr    = head_inc;
      done         = 1'b0;
      status       = ST_OK;
      popped       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               done = 1'b1;
               unique case (cmd)
                  CMD_PUSH_FRONT: begin
                     if (q_full) begin
                        status = ST_FULL;
                     end else begin
                        head_in   = head_dec;
                        ram_we    = 1'b1;
                        ram_waddr = head_dec;
                        front_in  = word;
                        if (q_empty) begin
                           back_in = word;
                        end
                        occ_in = occ_ff + CW'(1);
                     end
                  end
                  CMD_PUSH_BACK: begin
                     if (q_full) begin
                        status = ST_FULL;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = wrap_idx(SW'(head_ff) + SW'(occ_ff));
                        back_in   = word;
                        if (q_empty) begin
                           front_in = word;
                        end
                        occ_in = occ_ff + CW'(1);
                     end
                  end
                  CMD_POP_FRONT: begin
                     if (q_empty) begin
                        status = ST_EMPTY;
                     end else begin
                        popped  = front_ff;
                        head_in = head_inc;
                        occ_in  = occ_ff - CW'(1);
                        if (occ_ff == CW'(2)) begin
                           front_in = back_ff;
                        end else if (occ_ff > CW'(2)) begin
                           // fetch the new front entry, finish next cycle
                           ram_re    = 1'b1;
                           ram_raddr = head_inc;
                           side_in   = 1'b1;
                           popped_in = front_ff;
                           done      = 1'b0;
                           state_in  = S_READ;
                        end
                     end
                  end
                  CMD_POP_BACK: begin
                     if (q_empty) begin
                        status = ST_EMPTY;
                     end else begin
                        popped = back_ff;
                        occ_in = occ_ff - CW'(1);
                        if (occ_ff == CW'(2)) begin
                           back_in = front_ff;
                        end else if (occ_ff > CW'(2)) begin
                           // fetch the new back entry, finish next cycle
                           ram_re    = 1'b1;
                           ram_raddr = wrap_idx(SW'(head_ff) + SW'(occ_ff) - SW'(2));
                           side_in   = 1'b0;
                           popped_in = back_ff;
                           done      = 1'b0;
                           state_in  = S_READ;
                        end
                     end
                  end
                  default: begin
                     // query and unused codes: report only
                  end
               endcase
            end
         end
         S_READ: begin
            done   = 1'b1;
            popped = popped_ff;
            if (side_ff) begin
               front_in = ram_rdata;
            end else begin
               back_in = ram_rdata;
            end
         end
         S_HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      result.status       = status;
      result.popped_value = 32'(popped);
      result.entry_count  = 11'(occ_in);
      result.is_empty     = (occ_in == '0);
      result.front_value  = (occ_in == '0) ? '0 : 32'(front_in);
      result.back_value   = (occ_in == '0) ? '0 : 32'(back_in);

      if (done) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = result;
            state_in     = S_IDLE;
         end else begin
            // output still occupied: park the result
            res_in   = result;
            state_in = S_HOLD;
         end
      end
   end

   always_ff @(posedge clock) begin
      front_ff    <= front_in;
      back_ff     <= back_in;
      popped_ff   <= popped_in;
      side_ff     <= side_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   deq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (word),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `DEQ_ASSERT_IMPLY(a_hold_out_full, clock, reset, state_ff == S_HOLD, rsp_valid_ff, "held result without a full output register")
   `DEQ_ASSERT_NEXT(a_read_one_cycle, clock, reset, state_ff == S_READ, state_ff != S_READ, "RAM read wait longer than one cycle")
   `DEQ_ASSERT_IMPLY(a_write_when_idle, clock, reset, ram_we, (state_ff == S_IDLE) && !ram_re, "RAM write outside command accept")
   `DEQ_ASSERT_IMPLY(a_empty_zero, clock, reset, rsp_valid_ff && rsp_data_ff.is_empty, (rsp_data_ff.front_value == '0) && (rsp_data_ff.back_value == '0) && (rsp_data_ff.entry_count == '0), "empty result shows entries")

endmodule

`default_nettype wire

/* rtl/deq_ram.sv */
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
